/* rtl/brb_pkg.sv */
// shared constants, codes and controller/datapath interface types of the byte ring buffer
package brb_pkg;

   localparam int DEPTH      = 4096;
   localparam int LANES      = 8;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = 13;
   localparam int LANE_CNT_W = 4;
   localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int BYTES_W    = 64;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic write_byte;
      logic read_issue;
      logic read_capture;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_write;
      logic start_read;
      logic last;
   } status_type;

endpackage

/* rtl/brb_ctrl.sv */
// sequencing state machine of the byte ring buffer
module brb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  brb_pkg::status_type status,
   output brb_pkg::cmd_type    cmd
);
   import brb_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_WRITE    = 5'b00010,
      ST_READ_REQ = 5'b00100,
      ST_READ_CAP = 5'b01000,
      ST_DONE     = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.start_write) begin
                  state_in = ST_WRITE;
               end else if (status.start_read) begin
                  state_in = ST_READ_REQ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WRITE: begin
            cmd.write_byte = 1'b1;
            if (status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ_REQ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_READ_CAP;
         end
         ST_READ_CAP: begin
            cmd.read_capture = 1'b1;
            state_in         = status.last ? ST_DONE : ST_READ_REQ;
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/brb_dp.sv */
// pointers, count, byte storage and result registers of the byte ring buffer
module brb_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [brb_pkg::CNT_W-1:0]        csr_wdata,
   input  logic [1:0]                       req_func,
   input  logic [brb_pkg::BYTES_W-1:0]      req_write_bytes,
   input  logic [brb_pkg::LANE_CNT_W-1:0]   req_write_count,
   input  logic [brb_pkg::LANE_CNT_W-1:0]   req_read_max,
   input  brb_pkg::cmd_type                 cmd,
   output brb_pkg::status_type              status,
   output logic                             rsp_write_ok,
   output logic [brb_pkg::LANE_CNT_W-1:0]   rsp_read_count,
   output logic [brb_pkg::BYTES_W-1:0]      rsp_read_bytes,
   output logic [brb_pkg::CNT_W-1:0]        rsp_bytes_stored,
   output logic [brb_pkg::CNT_W-1:0]        rsp_space_free
);
   import brb_pkg::*;

   localparam logic [LANE_CNT_W-1:0] LANES_CNT = LANE_CNT_W'(LANES);

   logic [7:0] mem [DEPTH];
   logic [7:0] ram_q_ff;

   logic [CNT_W-1:0]      size_ff, size_in;
   logic [PTR_W-1:0]      rptr_ff, rptr_in;
   logic [PTR_W-1:0]      wptr_ff, wptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [LANE_CNT_W-1:0] left_ff, left_in;
   logic [LANE_IDX_W-1:0] lane_ff, lane_in;
   logic                  ok_ff, ok_in;
   logic [LANE_CNT_W-1:0] rcount_ff, rcount_in;
   logic [LANES-1:0][7:0] wdata_ff, wdata_in;
   logic [LANES-1:0][7:0] rdata_ff, rdata_in;

   logic [LANE_CNT_W-1:0] wc_sat, rm_sat, rd_n;
   logic [CNT_W-1:0]      space;
   logic                  fits, is_write, is_read, is_clear;
   logic [CNT_W-1:0]      size_clamp;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                    input logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(p) + CNT_W'(1);
      return (nxt >= size) ? '0 : nxt[PTR_W-1:0];
   endfunction

   assign wc_sat   = (req_write_count > LANES_CNT) ? LANES_CNT : req_write_count;
   assign rm_sat   = (req_read_max > LANES_CNT) ? LANES_CNT : req_read_max;
   assign space    = size_ff - cnt_ff;
   assign fits     = (cnt_ff < size_ff) && (CNT_W'(wc_sat) <= space);
   assign rd_n     = (cnt_ff < CNT_W'(rm_sat)) ? cnt_ff[LANE_CNT_W-1:0] : rm_sat;
   assign is_write = (req_func == FUNC_WRITE);
   assign is_read  = (req_func == FUNC_READ);
   assign is_clear = (req_func == FUNC_CLEAR);

   assign status.start_write = is_write && fits && (wc_sat != '0);
   assign status.start_read  = is_read && (rd_n != '0);
   assign status.last        = (left_ff == LANE_CNT_W'(1));

   always_comb begin
      priority if (csr_wdata == '0) begin
         size_clamp = CNT_W'(1);
      end else if (csr_wdata > CNT_W'(DEPTH)) begin
         size_clamp = CNT_W'(DEPTH);
      end else begin
         size_clamp = csr_wdata;
      end
   end

   always_comb begin
      size_in   = size_ff;
      rptr_in   = rptr_ff;
      wptr_in   = wptr_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;
      lane_in   = lane_ff;
      ok_in     = ok_ff;
      rcount_in = rcount_ff;
      wdata_in  = wdata_ff;
      rdata_in  = rdata_ff;
      priority if (csr_we) begin
         // a size change empties the ring
         size_in = size_clamp;
         rptr_in = '0;
         wptr_in = '0;
         cnt_in  = '0;
      end else if (cmd.accept) begin
         wdata_in  = req_write_bytes;
         rdata_in  = '0;
         lane_in   = '0;
         ok_in     = is_write && fits;
         rcount_in = is_read ? rd_n : '0;
         left_in   = is_read ? rd_n : wc_sat;
         if (is_write && fits) begin
            cnt_in = cnt_ff + CNT_W'(wc_sat);
         end else if (is_read) begin
            cnt_in = cnt_ff - CNT_W'(rd_n);
         end else if (is_clear) begin
            rptr_in = '0;
            wptr_in = '0;
            cnt_in  = '0;
         end
      end else if (cmd.write_byte) begin
         wptr_in = ptr_advance(wptr_ff, size_ff);
         lane_in = lane_ff + LANE_IDX_W'(1);
         left_in = left_ff - LANE_CNT_W'(1);
      end else if (cmd.read_issue) begin
         rptr_in = ptr_advance(rptr_ff, size_ff);
      end else if (cmd.read_capture) begin
         rdata_in[lane_ff] = ram_q_ff;
         lane_in           = lane_ff + LANE_IDX_W'(1);
         left_in           = left_ff - LANE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CNT_W'(DEPTH);
         rptr_ff <= '0;
         wptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         size_ff <= size_in;
         rptr_ff <= rptr_in;
         wptr_ff <= wptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      lane_ff   <= lane_in;
      ok_ff     <= ok_in;
      rcount_ff <= rcount_in;
      wdata_ff  <= wdata_in;
      rdata_ff  <= rdata_in;
   end

   // byte storage, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         mem[wptr_ff] <= wdata_ff[lane_ff];
      end
      ram_q_ff <= mem[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_write_ok     <= ok_ff;
         rsp_read_count   <= rcount_ff;
         rsp_read_bytes   <= rdata_ff;
         rsp_bytes_stored <= cnt_ff;
         rsp_space_free   <= size_ff - cnt_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= size_ff)
      else $error("stored count exceeds buffer size");
   assert property (@(posedge clock) disable iff (reset) CNT_W'(rptr_ff) < size_ff)
      else $error("read pointer outside storage in use");
   assert property (@(posedge clock) disable iff (reset) CNT_W'(wptr_ff) < size_ff)
      else $error("write pointer outside storage in use");

endmodule

/* rtl/byte_ring_buffer_block_transfer_unit.sv */
// top level of the byte ring buffer with block transfers
//
// req_ channel: one beat carries an operation (write block, read block,
// clear) with up to eight write bytes and a read limit. rsp_ channel: one
// beat per request with write status, read bytes and the fill status.
// csr_we/csr_wdata set the buffer size in use and empty the ring; write it
// only while no request is in flight.
// Bytes move one at a time through a byte memory with one write port and
// one registered read port. A write passes one write state per byte and a
// read an address state and a registered-read capture state per byte;
// clear and refused or empty operations go straight to the done state.
// A new request is taken the cycle after the previous result is loaded into
// the output register, so the block takes no new request while busy.
// Reset empties the ring and sets the size to the full 4096 bytes; memory
// contents are not cleared, no clearing pass is needed. When the receiver
// stalls, the result holds in the output register; the next request is
// still accepted and processed, and waits to deliver until the register
// frees up.
module byte_ring_buffer_block_transfer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [brb_pkg::CNT_W-1:0]      csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_func,
   input  logic [brb_pkg::BYTES_W-1:0]    req_write_bytes,
   input  logic [brb_pkg::LANE_CNT_W-1:0] req_write_count,
   input  logic [brb_pkg::LANE_CNT_W-1:0] req_read_max,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_write_ok,
   output logic [brb_pkg::LANE_CNT_W-1:0] rsp_read_count,
   output logic [brb_pkg::BYTES_W-1:0]    rsp_read_bytes,
   output logic [brb_pkg::CNT_W-1:0]      rsp_bytes_stored,
   output logic [brb_pkg::CNT_W-1:0]      rsp_space_free
);
   import brb_pkg::*;

   cmd_type    cmd;
   status_type status;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_func         (req_func),
      .req_write_bytes  (req_write_bytes),
      .req_write_count  (req_write_count),
      .req_read_max     (req_read_max),
      .cmd              (cmd),
      .status           (status),
      .rsp_write_ok     (rsp_write_ok),
      .rsp_read_count   (rsp_read_count),
      .rsp_read_bytes   (rsp_read_bytes),
      .rsp_bytes_stored (rsp_bytes_stored),
      .rsp_space_free   (rsp_space_free)
   );

endmodule

/* test/testbench.sv */
// self-checking testbench for the byte ring buffer block transfer unit
module testbench;
   import brb_pkg::*;

   localparam logic [1:0] FUNC_NONE   = 2'd3;
   localparam int         RING_MAX    = 4096;
   localparam int         LANE_MAX    = 8;
   localparam int         CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [1:0]            func;
      logic [BYTES_W-1:0]    write_bytes;
      logic [LANE_CNT_W-1:0] write_count;
      logic [LANE_CNT_W-1:0] read_max;
   } ring_req_type;

   typedef struct packed {
      logic                  write_ok;
      logic [LANE_CNT_W-1:0] read_count;
      logic [BYTES_W-1:0]    read_bytes;
      logic [CNT_W-1:0]      bytes_stored;
      logic [CNT_W-1:0]      space_free;
   } ring_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CNT_W-1:0]      csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func = FUNC_WRITE;
   logic [BYTES_W-1:0]    req_write_bytes = '0;
   logic [LANE_CNT_W-1:0] req_write_count = '0;
   logic [LANE_CNT_W-1:0] req_read_max = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_write_ok;
   logic [LANE_CNT_W-1:0] rsp_read_count;
   logic [BYTES_W-1:0]    rsp_read_bytes;
   logic [CNT_W-1:0]      rsp_bytes_stored;
   logic [CNT_W-1:0]      rsp_space_free;

   byte_ring_buffer_block_transfer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_write_bytes  (req_write_bytes),
      .req_write_count  (req_write_count),
      .req_read_max     (req_read_max),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_ok     (rsp_write_ok),
      .rsp_read_count   (rsp_read_count),
      .rsp_read_bytes   (rsp_read_bytes),
      .rsp_bytes_stored (rsp_bytes_stored),
      .rsp_space_free   (rsp_space_free)
   );

   always #6 clock = ~clock;

   // shadow copy of the ring
   logic [7:0] ring_mem [RING_MAX];
   int         ring_size = RING_MAX;
   int         rd_ptr = 0;
   int         wr_ptr = 0;
   int         fill = 0;

   ring_req_type  pending_reqs [$];
   ring_rsp_type  expected_rsps [$];
   int            queued_total = 0;
   int            accepted_total = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   int         size_writes = 0;
   int         refused_writes = 0;
   int         data_reads = 0;
   int         full_hits = 0;

   function automatic int next_ptr(input int p);
      return (p + 1 >= ring_size) ? 0 : p + 1;
   endfunction

   // update the shadow ring with one accepted beat and queue its result
   function automatic void ring_transfer(input ring_req_type r);
      ring_rsp_type e;
      int           wn;
      int           rn;
      int           i;
      e  = '0;
      wn = (r.write_count > LANE_MAX) ? LANE_MAX : int'(r.write_count);
      rn = (r.read_max > LANE_MAX) ? LANE_MAX : int'(r.read_max);
      case (r.func)
         FUNC_WRITE: begin
            if (fill < ring_size && wn <= ring_size - fill) begin
               for (i = 0; i < wn; i++) begin
                  ring_mem[wr_ptr] = r.write_bytes[8*i +: 8];
                  wr_ptr = next_ptr(wr_ptr);
               end
               fill += wn;
               e.write_ok = 1'b1;
            end else begin
               refused_writes++;
            end
         end
         FUNC_READ: begin
            if (fill < rn) rn = fill;
            for (i = 0; i < rn; i++) begin
               e.read_bytes[8*i +: 8] = ring_mem[rd_ptr];
               rd_ptr = next_ptr(rd_ptr);
            end
            fill -= rn;
            e.read_count = rn[LANE_CNT_W-1:0];
            if (rn > 0) data_reads++;
         end
         FUNC_CLEAR: begin
            rd_ptr = 0;
            wr_ptr = 0;
            fill   = 0;
         end
         default: ;
      endcase
      if (fill == ring_size) full_hits++;
      e.bytes_stored = fill[CNT_W-1:0];
      e.space_free   = CNT_W'(ring_size - fill);
      expected_rsps.push_back(e);
   endfunction

   // sender: bursts of random length with random gaps
   int           burst_left = 0;
   int           gap_left = 0;
   ring_req_type cur_req = '0;

   always @(posedge clock) begin : drive_proc
      ring_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            ring_transfer(cur_req);
            accepted_total = accepted_total + 1;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               cur_req         <= nxt;
               req_func        <= nxt.func;
               req_write_bytes <= nxt.write_bytes;
               req_write_count <= nxt.write_count;
               req_read_max    <= nxt.read_max;
               req_valid       <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern cycles through four modes
   int rx_tick = 0;

   always @(posedge clock) begin : check_proc
      ring_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat with no request waiting for it");
               fail_count = fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_write_ok !== want.write_ok) begin
                  $error("write_ok: expected %0d, got %0d", want.write_ok, rsp_write_ok);
                  fail_count = fail_count + 1;
               end
               if (rsp_read_count !== want.read_count) begin
                  $error("read_count: expected %0d, got %0d", want.read_count, rsp_read_count);
                  fail_count = fail_count + 1;
               end
               if (rsp_read_bytes !== want.read_bytes) begin
                  $error("read_bytes: expected %h, got %h", want.read_bytes, rsp_read_bytes);
                  fail_count = fail_count + 1;
               end
               if (rsp_bytes_stored !== want.bytes_stored) begin
                  $error("bytes_stored: expected %0d, got %0d", want.bytes_stored,
                         rsp_bytes_stored);
                  fail_count = fail_count + 1;
               end
               if (rsp_space_free !== want.space_free) begin
                  $error("space_free: expected %0d, got %0d", want.space_free, rsp_space_free);
                  fail_count = fail_count + 1;
               end
            end
         end
         rx_tick <= rx_tick + 1;
         case ((rx_tick / 200) % 4)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= (rx_tick % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_rsps.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] f, input logic [BYTES_W-1:0] data,
                           input logic [LANE_CNT_W-1:0] wc, input logic [LANE_CNT_W-1:0] rm);
      ring_req_type r;
      r.func        = f;
      r.write_bytes = data;
      r.write_count = wc;
      r.read_max    = rm;
      pending_reqs.push_back(r);
      queued_total++;
   endtask

   function automatic logic [LANE_CNT_W-1:0] pick_len();
      // mostly legal lengths, now and then an oversized one
      return LANE_CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                     : $urandom_range(0, 8));
   endfunction

   task automatic push_random(input int n, input int write_pct);
      int         k;
      int         pick;
      logic [1:0] f;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < write_pct)  f = FUNC_WRITE;
         else if (pick < 94)    f = FUNC_READ;
         else if (pick < 97)    f = FUNC_CLEAR;
         else                   f = FUNC_NONE;
         push_req(f, {$urandom, $urandom}, pick_len(), pick_len());
      end
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || expected_rsps.size() != 0) @(posedge clock);
   endtask

   // size register write also empties the ring
   task automatic set_ring_size(input logic [CNT_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      ring_size = (v == 0) ? 1 : (v > RING_MAX) ? RING_MAX : int'(v);
      rd_ptr    = 0;
      wr_ptr    = 0;
      fill      = 0;
      size_writes++;
   endtask

   initial begin : stim_proc
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full-size ring right after reset
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd8);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd0);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd0, 4'd0);
      push_req(FUNC_WRITE, 64'hffff_ffff_ffff_ffff, 4'd8, 4'd15);
      push_req(FUNC_WRITE, 64'h0, 4'd8, 4'd0);
      push_req(FUNC_WRITE, 64'h0123_4567_89ab_cdef, 4'd15, 4'd0);
      push_req(FUNC_NONE,  {$urandom, $urandom}, 4'd15, 4'd15);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd0);
      push_req(FUNC_READ,  64'hffff_ffff_ffff_ffff, 4'd15, 4'd15);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd3);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd8);
      push_req(FUNC_CLEAR, {$urandom, $urandom}, 4'd8, 4'd8);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd8);
      push_req(FUNC_WRITE, 64'h0000_0000_0000_00a5, 4'd1, 4'd0);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd7, 4'd0);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd8);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd3, 4'd0);
      wait_drained();

      // one-byte ring: full buffer refuses even an empty write
      set_ring_size(13'd1);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd8);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd1, 4'd0);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd0, 4'd0);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd1, 4'd0);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd8);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd0, 4'd0);
      push_random(120, 50);
      wait_drained();

      set_ring_size(13'd0);
      push_random(60, 50);
      wait_drained();

      // partial space: write refused though not full
      set_ring_size(13'd7);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd5, 4'd0);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd5, 4'd0);
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd2, 4'd0);
      push_req(FUNC_READ,  64'h0, 4'd0, 4'd15);
      push_random(150, 50);
      wait_drained();

      // out-of-range size clamps to the full depth; fill it completely
      set_ring_size(13'h1fff);
      for (k = 0; k < 520; k++)
         push_req(FUNC_WRITE, {$urandom, $urandom}, (k % 40 == 39) ? 4'd15 : 4'd8,
                  LANE_CNT_W'($urandom_range(0, 15)));
      push_req(FUNC_WRITE, {$urandom, $urandom}, 4'd0, 4'd0);
      for (k = 0; k < 30; k++)
         push_req(FUNC_READ, {$urandom, $urandom}, LANE_CNT_W'($urandom_range(0, 15)), 4'd8);
      wait_drained();

      set_ring_size(13'd16);
      push_random(200, 50);
      wait_drained();

      set_ring_size(13'd4096);
      push_random(150, 60);
      wait_drained();

      set_ring_size(13'd9);
      push_random(150, 50);
      wait_drained();

      for (k = 0; k < 3; k++) begin
         set_ring_size(CNT_W'($urandom_range(1, 40)));
         push_random(100, $urandom_range(35, 65));
         wait_drained();
      end

      set_ring_size(CNT_W'($urandom_range(0, 8191)));
      push_random(80, 55);
      wait_drained();

      repeat (20) @(posedge clock);
      $display("ran %0d requests over %0d ring sizes in %0d cycles", accepted_total,
               size_writes + 1, cycle_count);
      $display("refused writes %0d, reads returning data %0d, steps ending full %0d",
               refused_writes, data_reads, full_hits);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
